// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// QAU_ASSERT checks on every clock edge outside reset.
// QAU_ASSERT_RST also checks while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define QAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define QAU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define QAU_ASSERT(lbl, prop, msg)

`define QAU_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== hdl/qau_pkg.sv =====
`timescale 1ns / 1ps

package qau_pkg;

    // Component format and derived widths
    localparam int DW   = 16;             // component width
    localparam int FB   = 14;             // fraction bits
    localparam int SCW  = 18;             // scale factor width
    localparam int OPW  = 3;              // opcode width
    localparam int MAW  = DW + 1;         // left multiplier operand (holds a negated minimum)
    localparam int MBW  = SCW;            // right multiplier operand
    localparam int PW   = MAW + MBW;      // product width
    localparam int P2W  = 2 * DW;         // second-pass product width
    localparam int SW   = PW - FB + 3;    // rounded sum of four products
    localparam int NS   = 7;              // pipeline stages

    typedef logic [OPW-1:0]        t_opcode;
    typedef logic signed [DW-1:0]  t_comp;
    typedef logic signed [SCW-1:0] t_scale;
    typedef logic signed [MAW-1:0] t_opa;
    typedef logic signed [MBW-1:0] t_opb;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [P2W-1:0] t_prod2;
    typedef logic signed [SW-1:0]  t_sum;

    // Opcodes
    localparam t_opcode OP_MUL   = t_opcode'(0);
    localparam t_opcode OP_ADD   = t_opcode'(1);
    localparam t_opcode OP_SUB   = t_opcode'(2);
    localparam t_opcode OP_NEG   = t_opcode'(3);
    localparam t_opcode OP_CONJ  = t_opcode'(4);
    localparam t_opcode OP_SCALE = t_opcode'(5);
    localparam t_opcode OP_ROT   = t_opcode'(6);
    localparam t_opcode OP_DER   = t_opcode'(7);

    // Round a product to nearest, ties up; extra_half drops one more bit
    function automatic t_sum round_prod(input t_prod p, input logic extra_half);
        logic signed [PW:0] half;
        logic signed [PW:0] biased;
        logic signed [PW:0] shifted;
        half    = extra_half ? ((PW+1)'(1) << FB) : ((PW+1)'(1) << (FB - 1));
        biased  = $signed({p[PW-1], p}) + half;
        shifted = extra_half ? (biased >>> (FB + 1)) : (biased >>> FB);
        return t_sum'(shifted);
    endfunction

    // True when a sum does not fit in a component
    function automatic logic sum_ovf(input t_sum x);
        return !((&x[SW-1:DW-1]) || !(|x[SW-1:DW-1]));
    endfunction

    // Clamp a sum to the component range
    function automatic t_comp sat_comp(input t_sum x);
        t_comp hi;
        t_comp lo;
        hi = {1'b0, {(DW-1){1'b1}}};
        lo = {1'b1, {(DW-1){1'b0}}};
        if (sum_ovf(x)) begin
            return x[SW-1] ? lo : hi;
        end
        return x[DW-1:0];
    endfunction

endpackage

// ===== hdl/qau_req_if.sv =====
`timescale 1ns / 1ps

interface qau_req_if import qau_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_comp   a_w;
    t_comp   a_x;
    t_comp   a_y;
    t_comp   a_z;
    t_comp   b_w;
    t_comp   b_x;
    t_comp   b_y;
    t_comp   b_z;
    t_scale  scale;

    modport source (
        output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale,
        input  ready
    );

    modport sink (
        input  valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale,
        output ready
    );
endinterface

// ===== hdl/qau_rsp_if.sv =====
`timescale 1ns / 1ps

interface qau_rsp_if import qau_pkg::*; ();
    logic  valid;
    logic  ready;
    t_comp r_w;
    t_comp r_x;
    t_comp r_y;
    t_comp r_z;
    logic  overflow;

    modport source (
        output valid, r_w, r_x, r_y, r_z, overflow,
        input  ready
    );

    modport sink (
        input  valid, r_w, r_x, r_y, r_z, overflow,
        output ready
    );
endinterface

// ===== hdl/quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Transaction contents
// i_req     in         opcode, quaternion A, quaternion B or vector, scale
// o_rsp     out        result quaternion, overflow flag
//
// Seven register stages; one transaction in, one out.
// A new transaction may enter every cycle while the output is not stalled;
// the two multiply / round-and-sum passes each take one stage per step.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled output keeps filling bubbles upstream.
// Synchronous reset clears only the valid bits.

`include "assert_macros.svh"

module quaternion_arithmetic_unit import qau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qau_req_if.sink   i_req,
    qau_rsp_if.source o_rsp
);

    // Stage valids and load enables
    logic [NS:1]   r_valid;
    logic [NS:1]   n_valid;
    logic [NS+1:1] ld;

    // Stage 1: captured inputs
    t_opcode r_s1_op;
    t_comp   r_s1_a [4];
    t_comp   r_s1_b [4];
    t_scale  r_s1_k;

    // Stage 2: first product set
    t_opa    n_ma [4];
    t_opb    n_mb [4];
    t_opcode r_s2_op;
    t_comp   r_s2_a [4];
    t_comp   r_s2_b [4];
    t_prod   r_s2_p [4][4];

    // Stage 3: rounded sums or linear results
    t_sum    n_rp  [4][4];
    t_sum    n_s3  [4];
    t_opcode r_s3_op;
    t_comp   r_s3_a [4];
    t_sum    r_s3_s [4];

    // Stage 4: saturated intermediate
    logic    n_ovf4;
    t_opcode r_s4_op;
    t_comp   r_s4_a [4];
    t_comp   r_s4_t [4];
    logic    r_s4_ovf;

    // Stage 5: second product set
    t_opcode r_s5_op;
    t_comp   r_s5_t [4];
    logic    r_s5_ovf;
    t_prod2  r_s5_p [4][4];

    // Stage 6: rotation sums
    t_sum    n_rp2 [4][4];
    t_sum    n_s6  [4];
    t_opcode r_s6_op;
    t_sum    r_s6_s [4];
    logic    r_s6_ovf;

    // Stage 7: output register
    logic    n_ovf7;
    t_opcode r_s7_op;
    t_comp   r_s7_r [4];
    logic    r_s7_ovf;

    // Ripple load enables back from the output
    always_comb begin
        ld[NS+1] = o_rsp.ready;
        for (int k = NS; k >= 1; k--) begin
            ld[k] = !r_valid[k] || ld[k+1];
        end
    end

    assign i_req.ready = ld[1];
    assign n_valid     = {r_valid[NS-1:1], i_req.valid};

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (ld[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // Stage 1: capture the transaction
    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s1_op   <= i_req.opcode;
            r_s1_a[0] <= i_req.a_w;
            r_s1_a[1] <= i_req.a_x;
            r_s1_a[2] <= i_req.a_y;
            r_s1_a[3] <= i_req.a_z;
            r_s1_b[0] <= i_req.b_w;
            r_s1_b[1] <= i_req.b_x;
            r_s1_b[2] <= i_req.b_y;
            r_s1_b[3] <= i_req.b_z;
            r_s1_k    <= i_req.scale;
        end
    end

    // Select multiplier operands: conj(A) for rotation, pure vector for
    // rotation and derivative, the scale factor on every lane for scaling
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_ma[i] = t_opa'(r_s1_a[i]);
            if (r_s1_op == OP_ROT && i != 0) begin
                n_ma[i] = -t_opa'(r_s1_a[i]);
            end
        end
        unique case (r_s1_op)
            OP_SCALE: begin
                for (int j = 0; j < 4; j++) n_mb[j] = r_s1_k;
            end
            OP_ROT, OP_DER: begin
                n_mb[0] = '0;
                for (int j = 1; j < 4; j++) n_mb[j] = t_opb'(r_s1_b[j]);
            end
            default: begin
                for (int j = 0; j < 4; j++) n_mb[j] = t_opb'(r_s1_b[j]);
            end
        endcase
    end

    // Stage 2: all sixteen cross products
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s2_op <= r_s1_op;
            for (int i = 0; i < 4; i++) begin
                r_s2_a[i] <= r_s1_a[i];
                r_s2_b[i] <= r_s1_b[i];
                for (int j = 0; j < 4; j++) begin
                    r_s2_p[i][j] <= t_prod'(n_ma[i]) * t_prod'(n_mb[j]);
                end
            end
        end
    end

    // Round products and form the per-opcode sum
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_rp[i][j] = round_prod(r_s2_p[i][j], r_s2_op == OP_DER);
            end
        end
        for (int i = 0; i < 4; i++) n_s3[i] = '0;
        unique case (r_s2_op)
            OP_MUL, OP_ROT, OP_DER: begin
                n_s3[0] = n_rp[0][0] - n_rp[1][1] - n_rp[2][2] - n_rp[3][3];
                n_s3[1] = n_rp[0][1] + n_rp[1][0] + n_rp[2][3] - n_rp[3][2];
                n_s3[2] = n_rp[0][2] + n_rp[2][0] + n_rp[3][1] - n_rp[1][3];
                n_s3[3] = n_rp[0][3] + n_rp[3][0] + n_rp[1][2] - n_rp[2][1];
            end
            OP_ADD: begin
                for (int i = 0; i < 4; i++) n_s3[i] = t_sum'(r_s2_a[i]) + t_sum'(r_s2_b[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) n_s3[i] = t_sum'(r_s2_a[i]) - t_sum'(r_s2_b[i]);
            end
            OP_NEG: begin
                for (int i = 0; i < 4; i++) n_s3[i] = -t_sum'(r_s2_a[i]);
            end
            OP_CONJ: begin
                n_s3[0] = t_sum'(r_s2_a[0]);
                for (int i = 1; i < 4; i++) n_s3[i] = -t_sum'(r_s2_a[i]);
            end
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) n_s3[i] = n_rp[i][i];
            end
        endcase
    end

    // Stage 3: hold sums
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s3_op <= r_s2_op;
            for (int i = 0; i < 4; i++) begin
                r_s3_a[i] <= r_s2_a[i];
                r_s3_s[i] <= n_s3[i];
            end
        end
    end

    // Flag any component that leaves the range
    always_comb begin
        n_ovf4 = 1'b0;
        for (int i = 0; i < 4; i++) n_ovf4 = n_ovf4 | sum_ovf(r_s3_s[i]);
    end

    // Stage 4: saturate; this is the rotation intermediate or the final value
    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s4_op  <= r_s3_op;
            r_s4_ovf <= n_ovf4;
            for (int i = 0; i < 4; i++) begin
                r_s4_a[i] <= r_s3_a[i];
                r_s4_t[i] <= sat_comp(r_s3_s[i]);
            end
        end
    end

    // Stage 5: second product set, intermediate times A
    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_s5_op  <= r_s4_op;
            r_s5_ovf <= r_s4_ovf;
            for (int i = 0; i < 4; i++) begin
                r_s5_t[i] <= r_s4_t[i];
                for (int j = 0; j < 4; j++) begin
                    r_s5_p[i][j] <= t_prod2'(r_s4_t[i]) * t_prod2'(r_s4_a[j]);
                end
            end
        end
    end

    // Finish the rotation, real part dropped; pass other results through
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_rp2[i][j] = round_prod(t_prod'(r_s5_p[i][j]), 1'b0);
            end
        end
        if (r_s5_op == OP_ROT) begin
            n_s6[0] = '0;
            n_s6[1] = n_rp2[0][1] + n_rp2[1][0] + n_rp2[2][3] - n_rp2[3][2];
            n_s6[2] = n_rp2[0][2] + n_rp2[2][0] + n_rp2[3][1] - n_rp2[1][3];
            n_s6[3] = n_rp2[0][3] + n_rp2[3][0] + n_rp2[1][2] - n_rp2[2][1];
        end else begin
            for (int i = 0; i < 4; i++) n_s6[i] = t_sum'(r_s5_t[i]);
        end
    end

    // Stage 6: hold sums
    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_s6_op  <= r_s5_op;
            r_s6_ovf <= r_s5_ovf;
            for (int i = 0; i < 4; i++) r_s6_s[i] <= n_s6[i];
        end
    end

    // Merge overflow from both passes
    always_comb begin
        n_ovf7 = r_s6_ovf;
        for (int i = 0; i < 4; i++) n_ovf7 = n_ovf7 | sum_ovf(r_s6_s[i]);
    end

    // Stage 7: output register
    always_ff @(posedge i_clk) begin
        if (ld[7]) begin
            r_s7_op  <= r_s6_op;
            r_s7_ovf <= n_ovf7;
            for (int i = 0; i < 4; i++) r_s7_r[i] <= sat_comp(r_s6_s[i]);
        end
    end

    assign o_rsp.valid    = r_valid[NS];
    assign o_rsp.r_w      = r_s7_r[0];
    assign o_rsp.r_x      = r_s7_r[1];
    assign o_rsp.r_y      = r_s7_r[2];
    assign o_rsp.r_z      = r_s7_r[3];
    assign o_rsp.overflow = r_s7_ovf;

    `QAU_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_rsp.valid, "output valid after reset")
    `QAU_ASSERT(a_rot_w_zero, o_rsp.valid && r_s7_op == OP_ROT |-> o_rsp.r_w == '0, "rotation real part not zero")
    `QAU_ASSERT(a_mid_hold, r_valid[4] && !ld[5] |=> r_valid[4], "stalled stage dropped a transaction")
    `QAU_ASSERT(a_empty_out_ready, !r_valid[NS] |-> i_req.ready, "input blocked with empty output stage")

endmodule
